// ===== rtl/core/uvpm_pkg.sv =====
`default_nettype none
package uvpm_pkg;

	localparam int COORD_W = 24;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int ROOT_W  = COORD_W;
	localparam int CW      = COORD_W + 3;
	localparam int AW      = 34;
	localparam int ATW     = AW + 2;
	localparam int BW      = 34;
	localparam int TAB_LEN = 24;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam int TOL_W   = 8;

	localparam int DEF_FRAC_BITS     = 16;
	localparam int DEF_CORDIC_STAGES = 16;

	localparam logic REG_MAP_TYPE = 1'b0;
	localparam logic REG_FACE_TOL = 1'b1;

	typedef enum logic [1:0] {
		MAP_SPHERE = 2'd0,
		MAP_PLANE  = 2'd1,
		MAP_CYL    = 2'd2,
		MAP_BOX    = 2'd3
	} map_t;

	typedef struct packed {
		map_t                      map;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] pre_u;
		logic signed [COORD_W-1:0] pre_v;
	} side_t;

	localparam logic signed [ATW-1:0] SAT_HI = ATW'(2 ** (COORD_W - 1) - 1);
	localparam logic signed [ATW-1:0] SAT_LO = ATW'(-(2 ** (COORD_W - 1)));

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ATW-1:0] v);
		logic signed [ATW-1:0] t;
		begin
			t = v;
			if (t > SAT_HI) begin
				t = SAT_HI;
			end
			if (t < SAT_LO) begin
				t = SAT_LO;
			end
			return t[COORD_W-1:0];
		end
	endfunction

	// atan(2^-i), 2^32 units per full turn
	function automatic logic signed [AW-1:0] atan_tab(input int i);
		logic signed [AW-1:0] a;
		begin
			case (i)
				0:  a = 34'sd536870912;
				1:  a = 34'sd316933406;
				2:  a = 34'sd167458907;
				3:  a = 34'sd85004756;
				4:  a = 34'sd42667331;
				5:  a = 34'sd21354465;
				6:  a = 34'sd10679838;
				7:  a = 34'sd5340245;
				8:  a = 34'sd2670163;
				9:  a = 34'sd1335087;
				10: a = 34'sd667544;
				11: a = 34'sd333772;
				12: a = 34'sd166886;
				13: a = 34'sd83443;
				14: a = 34'sd41722;
				15: a = 34'sd20861;
				16: a = 34'sd10430;
				17: a = 34'sd5215;
				18: a = 34'sd2608;
				19: a = 34'sd1304;
				20: a = 34'sd652;
				21: a = 34'sd326;
				22: a = 34'sd163;
				23: a = 34'sd81;
				default: a = '0;
			endcase
			return a;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/uvpm_if.sv =====
`default_nettype none
interface uvpm_point_if;
	import uvpm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	modport source(output valid, output point_x, output point_y, output point_z, input ready);
	modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface uvpm_tex_if;
	import uvpm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] tex_u;
	logic signed [COORD_W-1:0] tex_v;
	modport source(output valid, output tex_u, output tex_v, input ready);
	modport sink(input valid, input tex_u, input tex_v, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/uvpm_front.sv =====
`default_nettype none
module uvpm_front #(
	parameter int FRAC_BITS = uvpm_pkg::DEF_FRAC_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic                               in_valid,
	input  wire logic signed [uvpm_pkg::COORD_W-1:0] x,
	input  wire logic signed [uvpm_pkg::COORD_W-1:0] y,
	input  wire logic signed [uvpm_pkg::COORD_W-1:0] z,
	input  wire uvpm_pkg::map_t                     map,
	input  wire logic [uvpm_pkg::TOL_W-1:0]          tol,
	output logic                                    out_valid,
	output logic [uvpm_pkg::SQ_W-1:0]               r2,
	output uvpm_pkg::side_t                         side
);
	import uvpm_pkg::*;

	localparam logic signed [BW-1:0] ONE  = BW'(1) <<< FRAC_BITS;
	localparam logic signed [BW-1:0] ONE2 = BW'(2) * ONE;
	localparam logic signed [BW-1:0] ONE3 = BW'(3) * ONE;

	function automatic logic near(input logic signed [COORD_W-1:0] c,
		input logic signed [BW-1:0] target, input logic [TOL_W-1:0] t);
		logic signed [BW-1:0] d;
		logic signed [BW-1:0] a;
		begin
			d = BW'(c) - target;
			a = d[BW-1] ? -d : d;
			return a <= $signed({{(BW-TOL_W){1'b0}}, t});
		end
	endfunction

	logic                      valid_s1;
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	map_t                      map_s1;
	logic [SQ_W-1:0]           sqx_s1, sqy_s1;
	logic [5:0]                near_s1;
	logic signed [SQ_W-1:0]    px, py;
	logic [5:0]                near_c;

	assign px = x * x;
	assign py = y * y;

	always_comb begin
		near_c[0] = near(x, -ONE, tol);
		near_c[1] = near(x, ONE, tol);
		near_c[2] = near(y, -ONE, tol);
		near_c[3] = near(y, ONE, tol);
		near_c[4] = near(z, -ONE, tol);
		near_c[5] = near(z, ONE, tol);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x;
			y_s1    <= y;
			z_s1    <= z;
			map_s1  <= map;
			sqx_s1  <= unsigned'(px);
			sqy_s1  <= unsigned'(py);
			near_s1 <= near_c;
		end
	end

	logic signed [BW-1:0] xe, ye, ze, nu, nv, bu, bv;
	side_t                side_c;

	always_comb begin
		xe = BW'(x_s1);
		ye = BW'(y_s1);
		ze = BW'(z_s1);
		nu = '0;
		nv = '0;
		if (near_s1[0]) begin
			nu = -ye - ONE3;
			nv = -ze;
		end else if (near_s1[1]) begin
			nu = ye + ONE;
			nv = -ze;
		end else if (near_s1[2]) begin
			nu = xe - ONE;
			nv = -ze - ONE2;
		end else if (near_s1[3]) begin
			nu = -xe - ONE;
			nv = -ze + ONE2;
		end else if (near_s1[4]) begin
			nu = xe + ONE3;
			nv = ye;
		end else if (near_s1[5]) begin
			nu = xe - ONE;
			nv = ye;
		end
		bu = (nu + BW'(2)) >>> 2;
		bv = (nv + BW'(2)) >>> 2;

		side_c.map   = map_s1;
		side_c.x     = x_s1;
		side_c.y     = y_s1;
		side_c.z     = z_s1;
		side_c.pre_u = '0;
		side_c.pre_v = '0;
		unique case (map_s1)
			MAP_PLANE: begin
				side_c.pre_u = x_s1;
				side_c.pre_v = y_s1;
			end
			MAP_CYL: begin
				side_c.pre_v = sat_coord(-ATW'(z_s1));
			end
			MAP_BOX: begin
				side_c.pre_u = sat_coord(ATW'(bu));
				side_c.pre_v = sat_coord(ATW'(bv));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2   <= sqx_s1 + sqy_s1;
			side <= side_c;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/uvpm_isqrt.sv =====
`default_nettype none
module uvpm_isqrt (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic [uvpm_pkg::SQ_W-1:0] n,
	input  wire uvpm_pkg::side_t         side_in,
	output logic                         out_valid,
	output logic [uvpm_pkg::ROOT_W-1:0]  root,
	output uvpm_pkg::side_t              side_out
);
	import uvpm_pkg::*;

	logic              valid_s [ROOT_W];
	logic [SQ_W-1:0]   rem_s   [ROOT_W];
	logic [ROOT_W-1:0] root_s  [ROOT_W];
	side_t             side_s  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - 1 - k;
		logic              v_in;
		logic [SQ_W-1:0]   r_in;
		logic [ROOT_W-1:0] q_in;
		side_t             sd_in;
		logic [SQ_W:0]     trial;
		logic              take;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = n;
			assign q_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = valid_s[k-1];
			assign r_in  = rem_s[k-1];
			assign q_in  = root_s[k-1];
			assign sd_in = side_s[k-1];
		end

		assign trial = ((SQ_W+1)'(q_in) << (B + 1)) + ((SQ_W+1)'(1) << (2 * B));
		assign take  = {1'b0, r_in} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? SQ_W'({1'b0, r_in} - trial) : r_in;
				root_s[k] <= take ? (q_in | (ROOT_W'(1) << B)) : q_in;
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = valid_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign side_out  = side_s[ROOT_W-1];

	logic [SQ_W:0] rem_bound;
	assign rem_bound = (SQ_W+1)'(root_s[ROOT_W-1]) << 1;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[ROOT_W-1] |-> ({1'b0, rem_s[ROOT_W-1]} <= rem_bound))
		else $error("square root remainder exceeds twice the root");

endmodule
`default_nettype wire

// ===== rtl/core/uvpm_cordic.sv =====
`default_nettype none
module uvpm_cordic #(
	parameter int CORDIC_STAGES = uvpm_pkg::DEF_CORDIC_STAGES
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic [uvpm_pkg::ROOT_W-1:0] root,
	input  wire uvpm_pkg::side_t          side_in,
	output logic                          out_valid,
	output logic signed [uvpm_pkg::AW-1:0] angle_a,
	output logic signed [uvpm_pkg::AW-1:0] angle_b,
	output uvpm_pkg::side_t               side_out
);
	import uvpm_pkg::*;

	localparam int ST = CORDIC_STAGES + 1;
	localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< 30;

	logic                 valid_s [ST];
	side_t                side_s  [ST];
	logic signed [CW-1:0] x_s     [ST][2];
	logic signed [CW-1:0] y_s     [ST][2];
	logic signed [AW-1:0] z_s     [ST][2];
	logic                 zero_s  [ST][2];

	logic signed [CW-1:0] xi [2];
	logic signed [CW-1:0] yi [2];

	assign xi[0] = CW'(side_in.x);
	assign yi[0] = CW'(side_in.y);
	assign xi[1] = CW'(side_in.z);
	assign yi[1] = CW'({1'b0, root});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[0][l] <= (xi[l] == '0) && (yi[l] == '0);
				if (xi[l][CW-1] && !yi[l][CW-1]) begin
					x_s[0][l] <= yi[l];
					y_s[0][l] <= -xi[l];
					z_s[0][l] <= QUARTER;
				end else if (xi[l][CW-1]) begin
					x_s[0][l] <= -yi[l];
					y_s[0][l] <= xi[l];
					z_s[0][l] <= -QUARTER;
				end else begin
					x_s[0][l] <= xi[l];
					y_s[0][l] <= yi[l];
					z_s[0][l] <= '0;
				end
			end
		end
	end

	for (genvar k = 1; k < ST; k++) begin : g_iter
		localparam int I = k - 1;
		localparam logic signed [AW-1:0] ANG = atan_tab(I);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_s[k-1];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic signed [CW-1:0] dx, dy;
			assign dx = y_s[k-1][l] >>> I;
			assign dy = x_s[k-1][l] >>> I;

			always_ff @(posedge clk) begin
				if (en) begin
					zero_s[k][l] <= zero_s[k-1][l];
					if (!y_s[k-1][l][CW-1]) begin
						x_s[k][l] <= x_s[k-1][l] + dx;
						y_s[k][l] <= y_s[k-1][l] - dy;
						z_s[k][l] <= z_s[k-1][l] + ANG;
					end else begin
						x_s[k][l] <= x_s[k-1][l] - dx;
						y_s[k][l] <= y_s[k-1][l] + dy;
						z_s[k][l] <= z_s[k-1][l] - ANG;
					end
				end
			end
		end
	end

	assign out_valid = valid_s[ST-1];
	assign side_out  = side_s[ST-1];
	assign angle_a   = zero_s[ST-1][0] ? '0 : z_s[ST-1][0];
	assign angle_b   = zero_s[ST-1][1] ? '0 : z_s[ST-1][1];

	a_prerot_right_half: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[0] |-> (!x_s[0][0][CW-1] && !x_s[0][1][CW-1]))
		else $error("pre-rotation left a vector in the left half plane");

endmodule
`default_nettype wire

// ===== rtl/core/uv_projection_mapper_top.sv =====
`default_nettype none
// Texture coordinate mapper: takes one hit point (x,y,z) per cycle unless tex is stalled
// and returns one (u,v) pair per item in the projection set by map_type (sphere, plane,
// cylinder, box). Every item runs the same pipeline: two front stages (squares, box face
// match and offsets), a 24-stage square root of x*x+y*y, one pre-rotation stage and
// CORDIC_STAGES vectoring CORDIC stages, and a final rounding and saturation stage, so
// throughput is one item per cycle unless tex is stalled. While tex is stalled with a
// valid result the whole pipeline holds and point.ready is low. Write registers through
// the APB port only while no items are in flight.
module uv_projection_mapper_top #(
	parameter int FRAC_BITS     = uvpm_pkg::DEF_FRAC_BITS,
	parameter int CORDIC_STAGES = uvpm_pkg::DEF_CORDIC_STAGES
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	uvpm_point_if.sink                       point,
	uvpm_tex_if.source                       tex,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [uvpm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [uvpm_pkg::DATA_W-1:0] pwdata,
	output logic [uvpm_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);
	import uvpm_pkg::*;

	localparam int SH = 31 - FRAC_BITS;
	localparam logic signed [ATW-1:0] RND  = ATW'(1) <<< (SH - 1);
	localparam logic signed [ATW-1:0] HALF = ATW'(1) <<< 31;

	map_t             map_type_q;
	logic [TOL_W-1:0] face_tol_q;
	logic             wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_type_q <= MAP_SPHERE;
			face_tol_q <= '0;
		end else if (wr) begin
			unique case (paddr[2])
				REG_MAP_TYPE: map_type_q <= map_t'(pwdata[1:0]);
				REG_FACE_TOL: face_tol_q <= pwdata[TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAP_TYPE: prdata = DATA_W'(map_type_q);
			REG_FACE_TOL: prdata = DATA_W'(face_tol_q);
			default:      prdata = '0;
		endcase
	end

	logic en;
	logic out_valid_q;

	assign en          = !out_valid_q || tex.ready;
	assign point.ready = en;

	logic            f_valid;
	logic [SQ_W-1:0] f_r2;
	side_t           f_side;

	uvpm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (point.valid),
		.x         (point.point_x),
		.y         (point.point_y),
		.z         (point.point_z),
		.map       (map_type_q),
		.tol       (face_tol_q),
		.out_valid (f_valid),
		.r2        (f_r2),
		.side      (f_side)
	);

	logic              q_valid;
	logic [ROOT_W-1:0] q_root;
	side_t             q_side;

	uvpm_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.n         (f_r2),
		.side_in   (f_side),
		.out_valid (q_valid),
		.root      (q_root),
		.side_out  (q_side)
	);

	logic                 c_valid;
	logic signed [AW-1:0] c_ang_a, c_ang_b;
	side_t                c_side;

	uvpm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (q_valid),
		.root      (q_root),
		.side_in   (q_side),
		.out_valid (c_valid),
		.angle_a   (c_ang_a),
		.angle_b   (c_ang_b),
		.side_out  (c_side)
	);

	logic signed [ATW-1:0]     ua, va;
	logic signed [COORD_W-1:0] u_c, v_c;

	always_comb begin
		ua  = (ATW'(c_ang_a) + RND) >>> SH;
		va  = ((ATW'(c_ang_b) <<< 1) - HALF + RND) >>> SH;
		u_c = c_side.pre_u;
		v_c = c_side.pre_v;
		if (c_side.map == MAP_SPHERE || c_side.map == MAP_CYL) begin
			u_c = sat_coord(ua);
		end
		if (c_side.map == MAP_SPHERE) begin
			v_c = sat_coord(va);
		end
	end

	logic signed [COORD_W-1:0] u_q, v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= c_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_q <= u_c;
			v_q <= v_c;
		end
	end

	assign tex.valid = out_valid_q;
	assign tex.tex_u = u_q;
	assign tex.tex_v = v_q;

	a_stall_reaches_input: assert property (@(posedge clk) disable iff (!arst_n)
		(tex.valid && !tex.ready) |-> !point.ready)
		else $error("input accepted while result stalled");

	a_map_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && paddr[2] == REG_MAP_TYPE) |=> (map_type_q == map_t'($past(pwdata[1:0]))))
		else $error("map_type write lost");

	a_tol_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && paddr[2] == REG_FACE_TOL) |=> (face_tol_q == $past(pwdata[TOL_W-1:0])))
		else $error("face_tolerance write lost");

endmodule
`default_nettype wire
